// ----- hw/rtl/imheq_pkg.sv -----
// Shared types, sizes and helper functions for the indexed min-heap event queue.
// Used by imheq_cmp and the top-level unit under hw/rtl (imheq_ram does not use it); depends on nothing.
package imheq_pkg;

  localparam int MAX_PROCESSES = 256;
  localparam int TIME_BITS     = 32;

  localparam int POS_W     = $clog2(MAX_PROCESSES);
  localparam int CNT_W     = $clog2(MAX_PROCESSES + 1);
  localparam int IDX_W     = POS_W + 2;
  localparam int ID_IN_W   = 8;
  localparam int TIME_IN_W = 32;
  localparam int CNT_OUT_W = 9;

  typedef logic [POS_W-1:0]     pos_t;
  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [TIME_BITS-1:0] stime_t;

  typedef struct packed {
    pos_t   id;
    stime_t tm;
  } heap_ent_t;

  localparam int HEAP_W = $bits(heap_ent_t);

  typedef enum logic [1:0] {
    ACT_ADD    = 2'd0,
    ACT_BUILD  = 2'd1,
    ACT_UPDATE = 2'd2,
    ACT_NOP    = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_FULL = 2'd1,
    STAT_NOID = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SLOT_LD,
    ST_BLD_RD,
    ST_BLD_LD,
    ST_UP_RD,
    ST_UP_CMP,
    ST_DN_RDL,
    ST_DN_RDR,
    ST_DN_CMPR,
    ST_DN_CMPC,
    ST_FINISH,
    ST_RESP
  } state_t;

  // Operand pairings of the shared time comparator.
  typedef enum logic [1:0] {
    CMP_UP,
    CMP_RIGHT,
    CMP_CUR
  } cmp_sel_t;

  function automatic stime_t to_stime(logic [TIME_IN_W-1:0] t);
    logic [TIME_BITS+TIME_IN_W-1:0] w;
    w = {{TIME_BITS{1'b0}}, t};
    return w[TIME_BITS-1:0];
  endfunction

  function automatic logic [TIME_IN_W-1:0] to_out_time(stime_t s);
    logic [TIME_BITS+TIME_IN_W-1:0] w;
    w = {{TIME_IN_W{1'b0}}, s};
    return w[TIME_IN_W-1:0];
  endfunction

  function automatic logic [ID_IN_W-1:0] id_to_out(pos_t id);
    logic [POS_W+ID_IN_W-1:0] w;
    w = {{ID_IN_W{1'b0}}, id};
    return w[ID_IN_W-1:0];
  endfunction

  function automatic logic [CNT_OUT_W-1:0] cnt_to_out(cnt_t c);
    logic [CNT_W+CNT_OUT_W-1:0] w;
    w = {{CNT_OUT_W{1'b0}}, c};
    return w[CNT_OUT_W-1:0];
  endfunction

endpackage

// ----- hw/rtl/imheq_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Stands alone; instantiated for the heap store and the position index.
module imheq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/imheq_cmp.sv -----
// Shared strict less-than unit for heap times, with its operand selection.
// Depends on imheq_pkg.
module imheq_cmp (
  input  imheq_pkg::cmp_sel_t sel,
  input  imheq_pkg::stime_t   cur_time,
  input  imheq_pkg::stime_t   best_time,
  input  imheq_pkg::stime_t   rd_time,
  output logic                less
);

  imheq_pkg::stime_t op_a;
  imheq_pkg::stime_t op_b;

  always_comb begin
    case (sel)
      imheq_pkg::CMP_UP: begin
        op_a = cur_time;
        op_b = rd_time;
      end
      imheq_pkg::CMP_RIGHT: begin
        op_a = rd_time;
        op_b = best_time;
      end
      imheq_pkg::CMP_CUR: begin
        op_a = best_time;
        op_b = cur_time;
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  // Ties never win, so equal times never move.
  assign less = op_a < op_b;

endmodule

// ----- hw/rtl/indexed_min_heap_event_queue_unit.sv -----
// Indexed min-heap event queue top: sequencer and datapath over imheq_ram and imheq_cmp.
// Depends on imheq_pkg. Add, no-op and refused words go from decode straight to the strobe;
// update sifts the entry up from its slot, then down. Build sifts each inner node down in turn,
// from the last inner node back to the root.
// One word in flight; busy is low in the strobe cycle, and results cannot be stalled.
// Reset (synchronous, active low) clears the count; the stores need no clearing.
module indexed_min_heap_event_queue_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_action,
  input  logic [7:0]  in_process_id,
  input  logic [31:0] in_time_value,
  output logic        out_valid,
  output logic [7:0]  out_top_process,
  output logic [31:0] out_top_time,
  output logic [8:0]  out_process_total,
  output logic [1:0]  out_status
);

  imheq_pkg::state_t    state_r, state_nxt;
  imheq_pkg::cnt_t      count_r, count_nxt;
  imheq_pkg::action_t   act_r, act_nxt;
  logic [imheq_pkg::ID_IN_W-1:0] id_r, id_nxt;
  imheq_pkg::stime_t    tin_r, tin_nxt;
  imheq_pkg::status_t   status_r, status_nxt;
  imheq_pkg::pos_t      cur_pos_r, cur_pos_nxt;
  imheq_pkg::pos_t      cur_id_r, cur_id_nxt;
  imheq_pkg::stime_t    cur_time_r, cur_time_nxt;
  imheq_pkg::pos_t      best_pos_r, best_pos_nxt;
  imheq_pkg::heap_ent_t best_ent_r, best_ent_nxt;
  imheq_pkg::pos_t      bidx_r, bidx_nxt;
  imheq_pkg::heap_ent_t root_r, root_nxt;

  logic                           heap_we;
  imheq_pkg::pos_t                heap_waddr;
  imheq_pkg::heap_ent_t           heap_wdata;
  imheq_pkg::pos_t                heap_raddr;
  logic [imheq_pkg::HEAP_W-1:0]   heap_rword;
  imheq_pkg::heap_ent_t           heap_rdata;
  logic                           slot_we;
  imheq_pkg::pos_t                slot_waddr;
  imheq_pkg::pos_t                slot_wdata;
  imheq_pkg::pos_t                slot_raddr;
  imheq_pkg::pos_t                slot_rdata;

  imheq_pkg::cmp_sel_t            cmp_sel;
  logic                           less;

  logic [imheq_pkg::IDX_W-1:0]    l_idx, r_idx, count_x;
  logic                           l_ok, r_ok;
  imheq_pkg::pos_t                l_pos, r_pos, parent_pos;
  logic [imheq_pkg::CNT_W+imheq_pkg::ID_IN_W-1:0] id_ext, count_ext;
  imheq_pkg::pos_t                id_pos;
  imheq_pkg::pos_t                count_pos;
  imheq_pkg::cnt_t                half_cnt;
  logic                           full;
  logic                           id_ok;
  logic                           accept;
  logic                           more_nodes;

  assign heap_rdata = imheq_pkg::heap_ent_t'(heap_rword);

  imheq_ram #(
    .WIDTH (imheq_pkg::HEAP_W),
    .DEPTH (imheq_pkg::MAX_PROCESSES)
  ) u_heap_ram (
    .clk   (clk),
    .we    (heap_we),
    .waddr (heap_waddr),
    .wdata (heap_wdata),
    .raddr (heap_raddr),
    .rdata (heap_rword)
  );

  imheq_ram #(
    .WIDTH (imheq_pkg::POS_W),
    .DEPTH (imheq_pkg::MAX_PROCESSES)
  ) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .raddr (slot_raddr),
    .rdata (slot_rdata)
  );

  imheq_cmp u_cmp (
    .sel       (cmp_sel),
    .cur_time  (cur_time_r),
    .best_time (best_ent_r.tm),
    .rd_time   (heap_rdata.tm),
    .less      (less)
  );

  // Child and parent positions of the moving entry.
  assign l_idx      = {1'b0, cur_pos_r, 1'b1};
  assign r_idx      = l_idx + imheq_pkg::IDX_W'(1);
  assign count_x    = imheq_pkg::IDX_W'(count_r);
  assign l_ok       = l_idx < count_x;
  assign r_ok       = r_idx < count_x;
  assign l_pos      = l_idx[imheq_pkg::POS_W-1:0];
  assign r_pos      = r_idx[imheq_pkg::POS_W-1:0];
  assign parent_pos = (cur_pos_r - imheq_pkg::pos_t'(1)) >> 1;

  assign id_ext     = {imheq_pkg::cnt_t'(0), id_r};
  assign count_ext  = {{imheq_pkg::ID_IN_W{1'b0}}, count_r};
  assign id_ok      = id_ext < count_ext;
  assign id_pos     = id_ext[imheq_pkg::POS_W-1:0];
  assign count_pos  = count_r[imheq_pkg::POS_W-1:0];
  assign half_cnt   = count_r >> 1;
  assign full       = count_r >= imheq_pkg::CNT_W'(imheq_pkg::MAX_PROCESSES);
  assign accept     = start && !busy;
  assign more_nodes = (act_r == imheq_pkg::ACT_BUILD) && (bidx_r != '0);
  assign slot_raddr = id_pos;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      imheq_pkg::ST_IDLE: begin
        if (start) state_nxt = imheq_pkg::ST_DECODE;
      end
      imheq_pkg::ST_DECODE: begin
        case (act_r)
          imheq_pkg::ACT_BUILD: begin
            state_nxt = (count_r > imheq_pkg::cnt_t'(1)) ? imheq_pkg::ST_BLD_RD
                                                         : imheq_pkg::ST_RESP;
          end
          imheq_pkg::ACT_UPDATE: begin
            state_nxt = id_ok ? imheq_pkg::ST_SLOT_LD : imheq_pkg::ST_RESP;
          end
          default: state_nxt = imheq_pkg::ST_RESP;
        endcase
      end
      imheq_pkg::ST_SLOT_LD: state_nxt = imheq_pkg::ST_UP_RD;
      imheq_pkg::ST_BLD_RD:  state_nxt = imheq_pkg::ST_BLD_LD;
      imheq_pkg::ST_BLD_LD:  state_nxt = imheq_pkg::ST_DN_RDL;
      imheq_pkg::ST_UP_RD: begin
        state_nxt = (cur_pos_r == '0) ? imheq_pkg::ST_DN_RDL : imheq_pkg::ST_UP_CMP;
      end
      imheq_pkg::ST_UP_CMP: begin
        state_nxt = less ? imheq_pkg::ST_UP_RD : imheq_pkg::ST_DN_RDL;
      end
      imheq_pkg::ST_DN_RDL: begin
        state_nxt = l_ok ? imheq_pkg::ST_DN_RDR : imheq_pkg::ST_FINISH;
      end
      imheq_pkg::ST_DN_RDR: begin
        state_nxt = r_ok ? imheq_pkg::ST_DN_CMPR : imheq_pkg::ST_DN_CMPC;
      end
      imheq_pkg::ST_DN_CMPR: state_nxt = imheq_pkg::ST_DN_CMPC;
      imheq_pkg::ST_DN_CMPC: begin
        state_nxt = less ? imheq_pkg::ST_DN_RDL : imheq_pkg::ST_FINISH;
      end
      imheq_pkg::ST_FINISH: begin
        state_nxt = more_nodes ? imheq_pkg::ST_BLD_RD : imheq_pkg::ST_RESP;
      end
      imheq_pkg::ST_RESP: begin
        state_nxt = start ? imheq_pkg::ST_DECODE : imheq_pkg::ST_IDLE;
      end
      default: state_nxt = imheq_pkg::ST_IDLE;
    endcase
  end

  // Store controls, comparator selection and handshake outputs.
  always_comb begin
    heap_we    = 1'b0;
    heap_waddr = cur_pos_r;
    heap_wdata = '{id: cur_id_r, tm: cur_time_r};
    heap_raddr = l_pos;
    slot_we    = 1'b0;
    slot_waddr = cur_id_r;
    slot_wdata = cur_pos_r;
    cmp_sel    = imheq_pkg::CMP_UP;
    out_valid  = 1'b0;
    busy       = 1'b1;
    case (state_r)
      imheq_pkg::ST_IDLE: busy = 1'b0;
      imheq_pkg::ST_DECODE: begin
        if (act_r == imheq_pkg::ACT_ADD && !full) begin
          heap_we    = 1'b1;
          heap_waddr = count_pos;
          heap_wdata = '{id: count_pos, tm: tin_r};
          slot_we    = 1'b1;
          slot_waddr = count_pos;
          slot_wdata = count_pos;
        end
      end
      imheq_pkg::ST_BLD_RD: heap_raddr = bidx_r;
      imheq_pkg::ST_UP_RD:  heap_raddr = parent_pos;
      imheq_pkg::ST_UP_CMP: begin
        cmp_sel = imheq_pkg::CMP_UP;
        // The parent drops into the hole left by the moving entry.
        if (less) begin
          heap_we    = 1'b1;
          heap_wdata = heap_rdata;
          slot_we    = 1'b1;
          slot_waddr = heap_rdata.id;
        end
      end
      imheq_pkg::ST_DN_RDL:  heap_raddr = l_pos;
      imheq_pkg::ST_DN_RDR:  heap_raddr = r_pos;
      imheq_pkg::ST_DN_CMPR: cmp_sel = imheq_pkg::CMP_RIGHT;
      imheq_pkg::ST_DN_CMPC: begin
        cmp_sel = imheq_pkg::CMP_CUR;
        if (less) begin
          heap_we    = 1'b1;
          heap_wdata = best_ent_r;
          slot_we    = 1'b1;
          slot_waddr = best_ent_r.id;
        end
      end
      imheq_pkg::ST_FINISH: begin
        heap_we = 1'b1;
        slot_we = 1'b1;
      end
      imheq_pkg::ST_RESP: begin
        out_valid = 1'b1;
        busy      = 1'b0;
      end
      default: busy = 1'b1;
    endcase
  end

  // Datapath register updates.
  always_comb begin
    count_nxt    = count_r;
    act_nxt      = act_r;
    id_nxt       = id_r;
    tin_nxt      = tin_r;
    status_nxt   = status_r;
    cur_pos_nxt  = cur_pos_r;
    cur_id_nxt   = cur_id_r;
    cur_time_nxt = cur_time_r;
    best_pos_nxt = best_pos_r;
    best_ent_nxt = best_ent_r;
    bidx_nxt     = bidx_r;
    if (accept) begin
      act_nxt = imheq_pkg::action_t'(in_action);
      id_nxt  = in_process_id;
      tin_nxt = imheq_pkg::to_stime(in_time_value);
    end
    case (state_r)
      imheq_pkg::ST_DECODE: begin
        status_nxt = imheq_pkg::STAT_OK;
        case (act_r)
          imheq_pkg::ACT_ADD: begin
            if (full) status_nxt = imheq_pkg::STAT_FULL;
            else      count_nxt  = count_r + imheq_pkg::cnt_t'(1);
          end
          imheq_pkg::ACT_BUILD: begin
            if (count_r == '0) status_nxt = imheq_pkg::STAT_NOID;
            bidx_nxt = half_cnt[imheq_pkg::POS_W-1:0] - imheq_pkg::pos_t'(1);
          end
          imheq_pkg::ACT_UPDATE: begin
            if (!id_ok) status_nxt = imheq_pkg::STAT_NOID;
          end
          default: begin
            if (count_r == '0) status_nxt = imheq_pkg::STAT_NOID;
          end
        endcase
      end
      imheq_pkg::ST_SLOT_LD: begin
        cur_pos_nxt  = slot_rdata;
        cur_id_nxt   = id_pos;
        cur_time_nxt = tin_r;
      end
      imheq_pkg::ST_BLD_LD: begin
        cur_pos_nxt  = bidx_r;
        cur_id_nxt   = heap_rdata.id;
        cur_time_nxt = heap_rdata.tm;
      end
      imheq_pkg::ST_UP_CMP: begin
        if (less) cur_pos_nxt = parent_pos;
      end
      imheq_pkg::ST_DN_RDR: begin
        best_ent_nxt = heap_rdata;
        best_pos_nxt = l_pos;
      end
      imheq_pkg::ST_DN_CMPR: begin
        if (less) begin
          best_ent_nxt = heap_rdata;
          best_pos_nxt = r_pos;
        end
      end
      imheq_pkg::ST_DN_CMPC: begin
        if (less) cur_pos_nxt = best_pos_r;
      end
      imheq_pkg::ST_FINISH: begin
        if (more_nodes) bidx_nxt = bidx_r - imheq_pkg::pos_t'(1);
      end
      default: begin
        cur_pos_nxt = cur_pos_r;
      end
    endcase
  end

  // The root is mirrored in flops so it can be reported without a read.
  assign root_nxt = (heap_we && heap_waddr == '0) ? heap_wdata : root_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= imheq_pkg::ST_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r      <= act_nxt;
    id_r       <= id_nxt;
    tin_r      <= tin_nxt;
    status_r   <= status_nxt;
    cur_pos_r  <= cur_pos_nxt;
    cur_id_r   <= cur_id_nxt;
    cur_time_r <= cur_time_nxt;
    best_pos_r <= best_pos_nxt;
    best_ent_r <= best_ent_nxt;
    bidx_r     <= bidx_nxt;
    root_r     <= root_nxt;
  end

  assign out_top_process   = (count_r == '0) ? '0 : imheq_pkg::id_to_out(root_r.id);
  assign out_top_time      = (count_r == '0) ? '0 : imheq_pkg::to_out_time(root_r.tm);
  assign out_process_total = imheq_pkg::cnt_to_out(count_r);
  assign out_status        = status_r;

  // An accepted word always passes through the decode state before its result strobe.
  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> !out_valid)
    else $error("result strobe in the cycle after accept");

  // The occupancy never exceeds the heap size.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= imheq_pkg::CNT_W'(imheq_pkg::MAX_PROCESSES))
    else $error("process count above heap size");

  // The moving entry always sits inside the occupied part of the heap.
  a_pos_in_heap: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == imheq_pkg::ST_UP_RD || state_r == imheq_pkg::ST_UP_CMP ||
     state_r == imheq_pkg::ST_DN_RDL || state_r == imheq_pkg::ST_DN_CMPC ||
     state_r == imheq_pkg::ST_FINISH) |-> (imheq_pkg::CNT_W'(cur_pos_r) < count_r))
    else $error("sift position outside the heap");

  // An empty heap can only ever report the unknown-or-empty status.
  a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && count_r == '0) |-> (status_r == imheq_pkg::STAT_NOID))
    else $error("empty heap reported without empty status");

endmodule
